@@ rtl/dpf_pkg.sv @@
// dpf_pkg: types and constants shared by the dedup packet FIFO block.
// Used by dpf_mem, dpf_ctrl and dedup_packet_fifo_with_range_count.
`default_nettype none

package dpf_pkg;

   localparam int SRC_W     = 16;
   localparam int DST_W     = 16;
   localparam int TS_W      = 30;
   localparam int OP_W      = 2;
   localparam int LIMIT_W   = 7;
   localparam int MCOUNT_W  = 7;
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 7'd64;
   localparam logic               REG_IDX_LIMIT = 1'b0;

   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_FWD   = 2'd1;
   localparam logic [OP_W-1:0] OP_COUNT = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

   typedef struct packed {
      logic [SRC_W-1:0] source;
      logic [DST_W-1:0] destination;
      logic [TS_W-1:0]  timestamp;
   } entry_type;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      entry_type        pkt;
      logic [TS_W-1:0]  start_time;
      logic [TS_W-1:0]  end_time;
   } req_type;

   typedef struct packed {
      logic                accepted;
      logic                packet_valid;
      entry_type           pkt;
      logic [MCOUNT_W-1:0] match_count;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic res_load;
   } ctrl_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FWD,
      ST_FINISH
   } ctrl_state_type;

endpackage

`default_nettype wire

@@ rtl/dpf_mem.sv @@
// dpf_mem: packet store, one write port and one registered read port.
// Depends on dpf_pkg for the entry type.
`default_nettype none

module dpf_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  wire                 clock,
   input  wire                 wr_en,
   input  wire [ADDR_W-1:0]    wr_addr,
   input  dpf_pkg::entry_type  wr_data,
   input  wire                 rd_en,
   input  wire [ADDR_W-1:0]    rd_addr,
   output dpf_pkg::entry_type  rd_data
);

   dpf_pkg::entry_type mem [DEPTH];
   dpf_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/dpf_ctrl.sv @@
// dpf_ctrl: request sequencer; scans the store for duplicate and count,
// pops for forward, and owns head pointer and fill count. Uses dpf_pkg.
`default_nettype none

module dpf_ctrl #(
   parameter int DEPTH = 64,
   parameter int PTR_W = 6,
   parameter int CNT_W = 7
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  dpf_pkg::req_type             req,
   input  wire [dpf_pkg::LIMIT_W-1:0]   limit,
   input  wire                          out_free,
   output dpf_pkg::ctrl_sts_type        sts,
   output dpf_pkg::rsp_type             res,
   output logic                         mem_wr_en,
   output logic [PTR_W-1:0]             mem_wr_addr,
   output dpf_pkg::entry_type           mem_wr_data,
   output logic                         mem_rd_en,
   output logic [PTR_W-1:0]             mem_rd_addr,
   input  dpf_pkg::entry_type           mem_rd_data
);

   localparam int LIM_W = (CNT_W > dpf_pkg::LIMIT_W) ? CNT_W : dpf_pkg::LIMIT_W;
   localparam int SUM_W = CNT_W + 1;

   dpf_pkg::ctrl_state_type state_ff, state_in;

   logic [PTR_W-1:0]              head_ff, head_in;
   logic [CNT_W-1:0]              fill_ff, fill_in;
   logic                          cmp_vld_ff;
   logic [CNT_W-1:0]              idx_ff;
   logic [PTR_W-1:0]              ptr_ff;
   logic                          dup_ff;
   logic [dpf_pkg::MCOUNT_W-1:0]  cnt_ff;
   dpf_pkg::req_type              req_ff;

   logic                 accept;
   logic                 issue;
   logic                 finish;
   logic                 dup_hit;
   logic                 cnt_hit;
   logic                 full;
   logic [LIM_W-1:0]     eff_limit;
   logic [SUM_W-1:0]     tail_sum;
   logic [PTR_W-1:0]     head_next;
   logic [PTR_W-1:0]     ptr_next;

   assign accept = req_valid && (state_ff == dpf_pkg::ST_IDLE);
   assign issue  = (state_ff == dpf_pkg::ST_SCAN) && (idx_ff != fill_ff);
   assign finish = (state_ff == dpf_pkg::ST_FINISH) && out_free;

   assign dup_hit = (mem_rd_data == req_ff.pkt);
   assign cnt_hit = (mem_rd_data.destination == req_ff.pkt.destination) &&
                    (mem_rd_data.timestamp >= req_ff.start_time) &&
                    (mem_rd_data.timestamp <= req_ff.end_time);

   always_comb begin
      eff_limit = LIM_W'(limit);
      if (eff_limit == '0) begin
         eff_limit = LIM_W'(1);
      end else if (eff_limit > LIM_W'(DEPTH)) begin
         eff_limit = LIM_W'(DEPTH);
      end
   end

   assign full = (LIM_W'(fill_ff) >= eff_limit);

   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(fill_ff);
      if (tail_sum >= SUM_W'(DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(DEPTH);
      end
   end

   assign head_next = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
   assign ptr_next  = (ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : ptr_ff + PTR_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dpf_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req.opcode)
                  dpf_pkg::OP_ADD, dpf_pkg::OP_COUNT: state_in = dpf_pkg::ST_SCAN;
                  dpf_pkg::OP_FWD:                    state_in = dpf_pkg::ST_FWD;
                  default:                            state_in = dpf_pkg::ST_FINISH;
               endcase
            end
         end
         dpf_pkg::ST_SCAN: begin
            if ((idx_ff == fill_ff) && !cmp_vld_ff) begin
               state_in = dpf_pkg::ST_FINISH;
            end
         end
         dpf_pkg::ST_FWD: begin
            state_in = dpf_pkg::ST_FINISH;
         end
         dpf_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = dpf_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // outputs and pointer updates
   always_comb begin
      mem_rd_en   = issue || (state_ff == dpf_pkg::ST_FWD);
      mem_rd_addr = (state_ff == dpf_pkg::ST_FWD) ? head_ff : ptr_ff;
      mem_wr_en   = finish && (req_ff.opcode == dpf_pkg::OP_ADD) && !dup_ff;
      mem_wr_addr = tail_sum[PTR_W-1:0];
      mem_wr_data = req_ff.pkt;

      res      = '0;
      head_in  = head_ff;
      fill_in  = fill_ff;
      if (finish) begin
         unique case (req_ff.opcode)
            dpf_pkg::OP_ADD: begin
               res.accepted = !dup_ff;
               if (!dup_ff) begin
                  // write slot is head + fill either way; eviction only moves head
                  if (full) begin
                     head_in = head_next;
                  end else begin
                     fill_in = fill_ff + CNT_W'(1);
                  end
               end
            end
            dpf_pkg::OP_FWD: begin
               if (fill_ff != '0) begin
                  res.packet_valid = 1'b1;
                  res.pkt          = mem_rd_data;
                  head_in          = head_next;
                  fill_in          = fill_ff - CNT_W'(1);
               end
            end
            dpf_pkg::OP_COUNT: begin
               res.match_count = cnt_ff;
            end
            default: begin
               res = '0;
            end
         endcase
      end

      sts.busy     = (state_ff != dpf_pkg::ST_IDLE);
      sts.res_load = finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dpf_pkg::ST_IDLE;
         head_ff    <= '0;
         fill_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         fill_ff    <= fill_in;
         cmp_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
         idx_ff <= '0;
         ptr_ff <= head_ff;
         dup_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (issue) begin
            idx_ff <= idx_ff + CNT_W'(1);
            ptr_ff <= ptr_next;
         end
         if (cmp_vld_ff) begin
            if (dup_hit) begin
               dup_ff <= 1'b1;
            end
            if (cnt_hit) begin
               cnt_ff <= cnt_ff + dpf_pkg::MCOUNT_W'(1);
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/dedup_packet_fifo_with_range_count.sv @@
// dedup_packet_fifo_with_range_count: top level, APB register, result register.
// Depends on dpf_pkg, dpf_mem and dpf_ctrl.
//
//   channel   handshake              payload
//   request   req_valid / req_stall  req_opcode, req_source, req_destination,
//                                    req_timestamp, req_start_time, req_end_time
//   result    rsp_valid / rsp_stall  rsp_accepted, rsp_packet_valid, rsp_out_*,
//                                    rsp_match_count
//   config    psel / penable / pready  paddr, pwdata, prdata (memory_limit at 0)
//
// Add and count walk every stored entry through the single read port of the store.
// Reset clears head, fill and the result valid; store contents are not cleared.
// A stalled result holds; the next request is taken meanwhile and waits at its end.
`default_nettype none

module dedup_packet_fifo_with_range_count #(
   parameter int BUFFER_DEPTH = 64
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire [dpf_pkg::OP_W-1:0]         req_opcode,
   input  wire [dpf_pkg::SRC_W-1:0]        req_source,
   input  wire [dpf_pkg::DST_W-1:0]        req_destination,
   input  wire [dpf_pkg::TS_W-1:0]         req_timestamp,
   input  wire [dpf_pkg::TS_W-1:0]         req_start_time,
   input  wire [dpf_pkg::TS_W-1:0]         req_end_time,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic                            rsp_accepted,
   output logic                            rsp_packet_valid,
   output logic [dpf_pkg::SRC_W-1:0]       rsp_out_source,
   output logic [dpf_pkg::DST_W-1:0]       rsp_out_destination,
   output logic [dpf_pkg::TS_W-1:0]        rsp_out_timestamp,
   output logic [dpf_pkg::MCOUNT_W-1:0]    rsp_match_count,
   input  wire                             psel,
   input  wire                             penable,
   input  wire                             pwrite,
   input  wire [dpf_pkg::PADDR_W-1:0]      paddr,
   input  wire [dpf_pkg::PDATA_W-1:0]      pwdata,
   output logic [dpf_pkg::PDATA_W-1:0]     prdata,
   output logic                            pready
);

   localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

   logic [dpf_pkg::LIMIT_W-1:0] limit_ff;
   logic                        rsp_valid_ff;
   dpf_pkg::rsp_type            rsp_ff;

   dpf_pkg::req_type       req;
   dpf_pkg::rsp_type       res;
   dpf_pkg::ctrl_sts_type  sts;
   logic                   out_free;
   logic                   csr_wr;

   logic                   mem_wr_en;
   logic [PTR_W-1:0]       mem_wr_addr;
   dpf_pkg::entry_type     mem_wr_data;
   logic                   mem_rd_en;
   logic [PTR_W-1:0]       mem_rd_addr;
   dpf_pkg::entry_type     mem_rd_data;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready &&
                   (paddr[2] == dpf_pkg::REG_IDX_LIMIT);
   assign prdata = (paddr[2] == dpf_pkg::REG_IDX_LIMIT) ?
                   dpf_pkg::PDATA_W'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= dpf_pkg::LIMIT_RESET;
      end else if (csr_wr) begin
         limit_ff <= pwdata[dpf_pkg::LIMIT_W-1:0];
      end
   end

   always_comb begin
      req.opcode          = req_opcode;
      req.pkt.source      = req_source;
      req.pkt.destination = req_destination;
      req.pkt.timestamp   = req_timestamp;
      req.start_time      = req_start_time;
      req.end_time        = req_end_time;
   end

   assign req_stall = sts.busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   dpf_ctrl #(
      .DEPTH (BUFFER_DEPTH),
      .PTR_W (PTR_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req         (req),
      .limit       (limit_ff),
      .out_free    (out_free),
      .sts         (sts),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   dpf_mem #(
      .DEPTH  (BUFFER_DEPTH),
      .ADDR_W (PTR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (sts.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sts.res_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_ff.accepted;
   assign rsp_packet_valid    = rsp_ff.packet_valid;
   assign rsp_out_source      = rsp_ff.pkt.source;
   assign rsp_out_destination = rsp_ff.pkt.destination;
   assign rsp_out_timestamp   = rsp_ff.pkt.timestamp;
   assign rsp_match_count     = rsp_ff.match_count;

`ifndef SYNTH
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while sequencer stayed idle");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      sts.res_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      sts.res_load |=> rsp_valid)
      else $error("loaded result not presented");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_packet_valid) &&
                    !((rsp_accepted || rsp_packet_valid) && (rsp_match_count != '0)))
      else $error("result carries fields of more than one operation");
`endif

endmodule

`default_nettype wire
